FILE: hw/rtl/sle_pkg.sv
// shared types and constants of the sequential list engine
package sle_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int POS_W   = 7;
  localparam int VALUE_W = 32;
  localparam int FOUND_W = 6;
  localparam int COUNT_W = 7;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_GET    = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

FILE: hw/rtl/sequential_list_engine.sv
// top level of the sequential list engine: array list held in one ram
//
//  channel | dir | handshake            | contents
//  in_     | in  | in_tvalid/in_tready  | tuser opcode, tdata position and value
//  out_    | out | out_tvalid/out_tready| tuser status, tdata value, position, count, empty
//
// insert moves each entry above the position up by one and find compares the entries
// from index 0 upward; both walk through the single ram read port, one entry per cycle
// reset clears the count and the control state only; entries above the count are
// never read before they are written, so the ram needs no clearing pass
// one result word is held in the output register; a stalled output makes the
// engine wait before it takes the next word
module sequential_list_engine
  import sle_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // position[6:0], item_value[38:7], zero[39]
  input  logic [1:0]             in_tuser,   // opcode[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // read_value[31:0], found_position[37:32], entry_count[44:38], is_empty[45], zero[47:46]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser   // status[1:0]
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int EXT_W  = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_FIND,
    S_GET_WAIT,
    S_RESP
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        scan_r, scan_nxt;
  logic [CNT_W-1:0]        pos_r, pos_nxt;
  logic [CNT_W-1:0]        wr_addr_r, wr_addr_nxt;
  logic                    wr_pend_r, wr_pend_nxt;
  logic [CNT_W-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic                    cmp_vld_r, cmp_vld_nxt;
  logic [DATA_WIDTH-1:0]   key_r, key_nxt;
  status_t                 res_status_r, res_status_nxt;
  logic [VALUE_W-1:0]      res_read_r, res_read_nxt;
  logic [FOUND_W-1:0]      res_found_r, res_found_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]  out_tdata_r, out_tdata_nxt;
  logic [1:0]              out_tuser_r, out_tuser_nxt;

  logic                    ram_wr_en;
  logic [ADDR_W-1:0]       ram_wr_addr;
  logic [DATA_WIDTH-1:0]   ram_wr_data;
  logic                    ram_rd_en;
  logic [ADDR_W-1:0]       ram_rd_addr;
  logic [DATA_WIDTH-1:0]   ram_rd_data;

  logic [POS_W-1:0]        in_pos;
  logic signed [VALUE_W-1:0] in_value;
  logic signed [EXT_W-1:0] value_ext;
  logic [DATA_WIDTH-1:0]   key_in;
  logic [CMP_W-1:0]        pos_c;
  logic [CMP_W-1:0]        cnt_c;
  logic [EXT_W-1:0]        rd_ext;
  logic [CMP_W-1:0]        cnt_out;
  logic [CMP_W-1:0]        idx_out;
  op_t                     in_op;

  sle_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_pos    = in_tdata[POS_W-1:0];
  assign in_value  = in_tdata[POS_W+VALUE_W-1:POS_W];
  assign in_op     = op_t'(in_tuser);
  // sign-extend the value, then keep the stored width
  assign value_ext = EXT_W'(in_value);
  assign key_in    = value_ext[DATA_WIDTH-1:0];
  assign pos_c     = CMP_W'(in_pos);
  assign cnt_c     = CMP_W'(count_r);
  assign rd_ext    = EXT_W'(ram_rd_data);
  assign cnt_out   = CMP_W'(count_r);
  assign idx_out   = CMP_W'(cmp_idx_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    pos_nxt        = pos_r;
    wr_addr_nxt    = wr_addr_r;
    wr_pend_nxt    = wr_pend_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_read_nxt   = res_read_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = '0;
    ram_wr_data    = '0;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_status_nxt = ST_OK;
          res_read_nxt   = '0;
          res_found_nxt  = '0;
          key_nxt        = key_in;
          unique case (in_op)
            OP_INSERT: begin
              if (pos_c > cnt_c) begin
                res_status_nxt = ST_BAD_POS;
                state_nxt      = S_RESP;
              end else if (count_r == CNT_W'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_RESP;
              end else begin
                scan_nxt    = count_r;
                pos_nxt     = pos_c[CNT_W-1:0];
                wr_pend_nxt = 1'b0;
                state_nxt   = S_SHIFT;
              end
            end
            OP_GET: begin
              if (pos_c >= cnt_c) begin
                res_status_nxt = ST_BAD_POS;
                state_nxt      = S_RESP;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = pos_c[ADDR_W-1:0];
                state_nxt   = S_GET_WAIT;
              end
            end
            OP_FIND: begin
              scan_nxt    = '0;
              cmp_vld_nxt = 1'b0;
              state_nxt   = S_FIND;
            end
            OP_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_RESP;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // the read of entry i-1 lands in the following cycle as the write of entry i
        if (wr_pend_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = wr_addr_r[ADDR_W-1:0];
          ram_wr_data = ram_rd_data;
        end
        if (scan_r > pos_r) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = ADDR_W'(scan_r - CNT_W'(1));
          wr_addr_nxt = scan_r;
          wr_pend_nxt = 1'b1;
          scan_nxt    = CNT_W'(scan_r - CNT_W'(1));
        end else begin
          wr_pend_nxt = 1'b0;
          if (!wr_pend_r) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_r[ADDR_W-1:0];
            ram_wr_data = key_r;
            count_nxt   = CNT_W'(count_r + CNT_W'(1));
            state_nxt   = S_RESP;
          end
        end
      end

      S_FIND: begin
        if (cmp_vld_r && (ram_rd_data == key_r)) begin
          res_status_nxt = ST_OK;
          res_found_nxt  = idx_out[FOUND_W-1:0];
          cmp_vld_nxt    = 1'b0;
          state_nxt      = S_RESP;
        end else if (scan_r < count_r) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = scan_r[ADDR_W-1:0];
          cmp_idx_nxt = scan_r;
          cmp_vld_nxt = 1'b1;
          scan_nxt    = CNT_W'(scan_r + CNT_W'(1));
        end else begin
          cmp_vld_nxt = 1'b0;
          if (!cmp_vld_r) begin
            res_status_nxt = ST_NOT_FOUND;
            state_nxt      = S_RESP;
          end
        end
      end

      S_GET_WAIT: begin
        res_read_nxt = rd_ext[VALUE_W-1:0];
        state_nxt    = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_tuser_nxt = res_status_r;
          out_tdata_nxt = {2'b00, (count_r == '0), cnt_out[COUNT_W-1:0],
                           res_found_r, res_read_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wr_pend_r   <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wr_pend_r   <= wr_pend_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_r       <= scan_nxt;
    pos_r        <= pos_nxt;
    wr_addr_r    <= wr_addr_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_read_r   <= res_read_nxt;
    res_found_r  <= res_found_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

endmodule

FILE: hw/rtl/sle_ram.sv
// generic simple dual-port ram with registered read
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: test/tb_sequential_list_engine.sv
// self-checking testbench for the sequential list engine: directed table, then random list ops
`timescale 1ns / 1ps

module tb_sequential_list_engine;
  import sle_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 100;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 100;
  localparam int FILL_AT     = 20;
  localparam int DIR_N       = 28;

  typedef struct packed {
    status_t     status;
    logic [31:0] read_value;
    logic [5:0]  found_pos;
    logic [6:0]  entry_count;
    logic        is_empty;
  } list_result_t;

  typedef struct packed {
    op_t          op;
    logic [6:0]   pos;
    logic [31:0]  val;
    logic         typed;
    list_result_t want;
  } dir_row_t;

  localparam logic [31:0] VALUE_POOL [8] = '{
    32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff,
    32'h8000_0000, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0003
  };

  // typed rows hold the obvious answer, the rest are predicted
  dir_row_t dir_table [DIR_N] = '{
    '{OP_GET,    7'd0,  32'h0,         1'b1, '{ST_BAD_POS,   32'h0, 6'd0, 7'd0,  1'b1}},
    '{OP_FIND,   7'd0,  32'h0,         1'b1, '{ST_NOT_FOUND, 32'h0, 6'd0, 7'd0,  1'b1}},
    '{OP_INSERT, 7'd1,  32'h5,         1'b1, '{ST_BAD_POS,   32'h0, 6'd0, 7'd0,  1'b1}},
    '{OP_INSERT, 7'd0,  32'h7fff_ffff, 1'b1, '{ST_OK,        32'h0, 6'd0, 7'd1,  1'b0}},
    '{OP_INSERT, 7'd0,  32'h8000_0000, 1'b1, '{ST_OK,        32'h0, 6'd0, 7'd2,  1'b0}},
    '{OP_INSERT, 7'd2,  32'hffff_ffff, 1'b1, '{ST_OK,        32'h0, 6'd0, 7'd3,  1'b0}},
    '{OP_INSERT, 7'd1,  32'h0,         1'b0, '0},
    '{OP_INSERT, 7'd4,  32'h7fff_ffff, 1'b0, '0},
    '{OP_GET,    7'd0,  32'h0,         1'b0, '0},
    '{OP_GET,    7'd4,  32'hffff_ffff, 1'b0, '0},
    '{OP_GET,    7'd5,  32'h0,         1'b1, '{ST_BAD_POS,   32'h0, 6'd0, 7'd5,  1'b0}},
    '{OP_GET,    7'd64, 32'h0,         1'b1, '{ST_BAD_POS,   32'h0, 6'd0, 7'd5,  1'b0}},
    '{OP_FIND,   7'd0,  32'h7fff_ffff, 1'b0, '0},
    '{OP_FIND,   7'd64, 32'hffff_ffff, 1'b0, '0},
    '{OP_FIND,   7'd0,  32'h1234_5678, 1'b1, '{ST_NOT_FOUND, 32'h0, 6'd0, 7'd5,  1'b0}},
    '{OP_INSERT, 7'd6,  32'h1,         1'b1, '{ST_BAD_POS,   32'h0, 6'd0, 7'd5,  1'b0}},
    '{OP_INSERT, 7'd64, 32'h1,         1'b1, '{ST_BAD_POS,   32'h0, 6'd0, 7'd5,  1'b0}},
    '{OP_CLEAR,  7'd64, 32'hffff_ffff, 1'b1, '{ST_OK,        32'h0, 6'd0, 7'd0,  1'b1}},
    '{OP_GET,    7'd0,  32'h0,         1'b1, '{ST_BAD_POS,   32'h0, 6'd0, 7'd0,  1'b1}},
    '{OP_FIND,   7'd0,  32'h0,         1'b1, '{ST_NOT_FOUND, 32'h0, 6'd0, 7'd0,  1'b1}},
    // list is full from here on
    '{OP_INSERT, 7'd64, 32'h9,         1'b1, '{ST_FULL,      32'h0, 6'd0, 7'd64, 1'b0}},
    '{OP_INSERT, 7'd0,  32'h9,         1'b1, '{ST_FULL,      32'h0, 6'd0, 7'd64, 1'b0}},
    // past-the-end check wins over the full check
    '{OP_INSERT, 7'd127, 32'h9,        1'b1, '{ST_BAD_POS,   32'h0, 6'd0, 7'd64, 1'b0}},
    '{OP_GET,    7'd63, 32'h0,         1'b0, '0},
    '{OP_GET,    7'd64, 32'h0,         1'b1, '{ST_BAD_POS,   32'h0, 6'd0, 7'd64, 1'b0}},
    '{OP_GET,    7'd127, 32'h0,        1'b1, '{ST_BAD_POS,   32'h0, 6'd0, 7'd64, 1'b0}},
    '{OP_FIND,   7'd0,  32'hffff_ffff, 1'b0, '0},
    '{OP_CLEAR,  7'd0,  32'h0,         1'b1, '{ST_OK,        32'h0, 6'd0, 7'd0,  1'b1}}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // position[6:0], item_value[38:7], zero[39]
  logic [1:0]             in_tuser = '0;   // opcode[1:0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // read_value[31:0], found_position[37:32], entry_count[44:38], is_empty[45], zero[47:46]
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;       // status[1:0]

  logic [31:0]  list_store [CAP];
  int           list_count;
  list_result_t pending_results [$];
  int           mismatch_cnt = 0;
  int           in_idle_pct = 0;
  int           out_idle_pct = 0;
  int           hold_requests = 0;
  int           hold_served = 0;
  int           hold_left = 0;
  int           cycle_cnt = 0;

  sequential_list_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("sequential_list_engine verification failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // array list behavior: shift-up insert, bounded get, lowest-index find, clear
  function automatic list_result_t predict_list_op(op_t op, logic [6:0] pos,
                                                   logic [31:0] val);
    list_result_t res;
    int idx;
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (int'(pos) > list_count) begin
          res.status = ST_BAD_POS;
        end else if (list_count >= CAP) begin
          res.status = ST_FULL;
        end else begin
          for (idx = list_count; idx > int'(pos); idx--)
            list_store[idx] = list_store[idx-1];
          list_store[pos] = val;
          list_count++;
        end
      end
      OP_GET: begin
        if (int'(pos) >= list_count) res.status = ST_BAD_POS;
        else res.read_value = list_store[pos];
      end
      OP_FIND: begin
        res.status = ST_NOT_FOUND;
        for (idx = list_count - 1; idx >= 0; idx--) begin
          if (list_store[idx] == val) begin
            res.status    = ST_OK;
            res.found_pos = 6'(idx);
          end
        end
      end
      default: begin
        for (idx = 0; idx < CAP; idx++) list_store[idx] = '0;
        list_count = 0;
      end
    endcase
    res.entry_count = 7'(list_count);
    res.is_empty    = (list_count == 0);
    return res;
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(99) < 40) return VALUE_POOL[$urandom_range(7)];
    return $urandom;
  endfunction

  // offer one word, keep tvalid high until taken, then record what should come back
  task automatic send_list_op(op_t op, logic [6:0] pos, logic [31:0] val,
                              logic typed, list_result_t want);
    list_result_t pred;
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, val, pos};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    pred = predict_list_op(op, pos, val);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_random_op();
    int r;
    op_t op;
    logic [6:0] pos;
    logic [31:0] val;
    r = $urandom_range(99);
    val = pick_value();
    pos = 7'($urandom_range(64));
    if (r == 0) begin
      op = OP_CLEAR;
    end else if (r < 50) begin
      op = OP_INSERT;
      if ($urandom_range(99) < 85 || list_count == CAP) pos = 7'($urandom_range(list_count));
      else pos = 7'($urandom_range(CAP, list_count + 1));
    end else if (r < 75) begin
      op = OP_GET;
      if (list_count > 0 && $urandom_range(99) < 85) pos = 7'($urandom_range(list_count - 1));
      else pos = 7'($urandom_range(CAP, list_count));
    end else begin
      op = OP_FIND;
      if (list_count > 0 && $urandom_range(99) < 60)
        val = list_store[$urandom_range(list_count - 1)];
    end
    send_list_op(op, pos, val, 1'b0, '0);
  endtask

  // result checker
  always @(posedge clk) begin
    list_result_t got, exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      got.status      = status_t'(out_tuser);
      got.read_value  = out_tdata[31:0];
      got.found_pos   = out_tdata[37:32];
      got.entry_count = out_tdata[44:38];
      got.is_empty    = out_tdata[45];
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result word: status %0d value %h pos %0d count %0d empty %0d",
                   got.status, got.read_value, got.found_pos, got.entry_count, got.is_empty);
      end else begin
        exp_res = pending_results.pop_front();
        if (got.status != exp_res.status || got.read_value != exp_res.read_value ||
            got.found_pos != exp_res.found_pos || got.entry_count != exp_res.entry_count ||
            got.is_empty != exp_res.is_empty) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: exp status %0d value %h pos %0d count %0d empty %0d",
                     exp_res.status, exp_res.read_value, exp_res.found_pos,
                     exp_res.entry_count, exp_res.is_empty);
            $display("          got status %0d value %h pos %0d count %0d empty %0d",
                     got.status, got.read_value, got.found_pos, got.entry_count,
                     got.is_empty);
          end
        end
      end
    end
  end

  initial begin
    int i;
    int k;
    for (i = 0; i < CAP; i++) list_store[i] = '0;
    list_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct  = 6;
    out_idle_pct = 47;
    for (i = 0; i < DIR_N; i++) begin
      if (i == FILL_AT) begin
        // fill to capacity at random positions, repeated values included
        for (k = 0; k < CAP; k++)
          send_list_op(OP_INSERT, 7'($urandom_range(list_count)), pick_value(), 1'b0, '0);
      end
      send_list_op(dir_table[i].op, dir_table[i].pos, dir_table[i].val,
                   dir_table[i].typed, dir_table[i].want);
    end
    wait_all_results();

    // long output stall while the input keeps offering words
    hold_requests = hold_requests + 1;
    for (i = 0; i < PHASE_ITEMS; i++) send_random_op();
    wait_all_results();

    in_idle_pct  = 47;
    out_idle_pct = 6;
    for (i = 0; i < PHASE_ITEMS; i++) send_random_op();
    wait_all_results();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    for (i = 0; i < PHASE_ITEMS; i++) send_random_op();
    wait_all_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("sequential_list_engine verification clean");
    end else begin
      $display("sequential_list_engine verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/sle_pkg.sv
hw/rtl/sle_ram.sv
hw/rtl/sequential_list_engine.sv
test/tb_sequential_list_engine.sv
